// ===== sv/knn_pkg.sv =====
// ----------------------------------------------------------------------------
// knn_pkg
// Shared widths and payload types for the histogram k-NN classifier.
// ----------------------------------------------------------------------------
package knn_pkg;
	localparam int CLASS_COUNT_D    = 4;
	localparam int REFS_PER_CLASS_D = 64;
	localparam int BIN_COUNT_D      = 32;
	localparam int BIN_BITS_D       = 16;

	localparam int ACC_W = 64;

	typedef struct packed {
		logic        req_type;
		logic [1:0]  class_id;
		logic [5:0]  sample_index;
		logic [4:0]  bin_index;
		logic [15:0] bin_value;
		logic        last_bin;
	} knn_in_t;

	typedef struct packed {
		logic [1:0] predicted_class;
		logic [5:0] winning_votes;
	} knn_out_t;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;
endpackage

// ===== sv/knn_histogram_classifier.sv =====
// ----------------------------------------------------------------------------
// knn_histogram_classifier
// k-nearest-neighbor classifier over stored integer histograms.
// ----------------------------------------------------------------------------
// Usage:
//  in  channel (in_valid/in_ready, in_data): one transaction is either a
//      reference bin load (req_type 0) or one bin of a query (req_type 1).
//  cfg channel (cfg_valid/cfg_ready, cfg_data): writes k_neighbors. Always
//      ready; write only while the block is idle.
//  out channel (out_valid/out_ready, out_data): one transaction per query,
//      produced after the bin marked last_bin.
// Sequence:
//  A load is written to the reference store as it is accepted. A query bin is
//  accepted, then the distance memory is swept, one read-modify-write a
//  cycle through a two-stage pipeline.
//  After the last bin, min(k, REF_TOTAL) selection passes each scan for the
//  smallest unselected distance; then selection is left and the votes are
//  tallied per class before out_valid.
// Reset: k_neighbors returns to 1. Distances read as zero through one valid
//  bit per reference; those bits, the selection marks and the vote counters
//  clear at reset and when the result is taken. The reference store is
//  undefined until written.
// Stall: if out_ready is low the result is held in out_data and no further
//  input is taken until it is delivered.
// ----------------------------------------------------------------------------
module knn_histogram_classifier import knn_pkg::*; #(
	parameter int CLASS_COUNT    = CLASS_COUNT_D,
	parameter int REFS_PER_CLASS = REFS_PER_CLASS_D,
	parameter int BIN_COUNT      = BIN_COUNT_D,
	parameter int BIN_BITS       = BIN_BITS_D
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  knn_in_t  in_data,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic [5:0] cfg_data,
	output logic     out_valid,
	input  logic     out_ready,
	output knn_out_t out_data
);
	localparam int REF_TOTAL = CLASS_COUNT * REFS_PER_CLASS;
	localparam int RW = (REF_TOTAL > 1) ? $clog2(REF_TOTAL) : 1;
	localparam int RCW = $clog2(REF_TOTAL + 1);
	localparam int CW = $clog2(CLASS_COUNT);
	localparam int CCW = $clog2(CLASS_COUNT + 1);
	localparam int BW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
	localparam int DEPTH = REF_TOTAL * BIN_COUNT;
	localparam int AW = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
	localparam int SQW = 2 * BIN_BITS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ACC   = 3'd1;
	localparam logic [2:0] ST_SEL   = 3'd2;
	localparam logic [2:0] ST_VOTE  = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0] state_q;
	logic [5:0] k_q;

	// memories
	logic [BIN_BITS-1:0] ref_mem [DEPTH];
	logic [ACC_W-1:0]    dist_mem [REF_TOTAL];
	logic [REF_TOTAL-1:0] dvalid_q;   // distance entry valid (else zero)
	logic [REF_TOTAL-1:0] sel_q;      // selected marks
	logic [5:0] votes_q [CLASS_COUNT];

	// sweep control
	logic [RCW-1:0] rd_cnt_q;         // read issue counter
	logic [BW-1:0]  bin_q;
	logic [BIN_BITS-1:0] qval_q;
	logic last_q;
	logic [5:0] k_left_q;

	// stage 1: read issued
	logic           v_s1;
	logic [RW-1:0]  r_s1;
	logic [BIN_BITS-1:0] refv_s1;
	logic [ACC_W-1:0] dist_s1;
	// stage 2: squared diff
	logic           v_s2;
	logic [RW-1:0]  r_s2;
	logic [SQW-1:0] sq_s2;
	logic [ACC_W-1:0] acc_s2;

	// selection scan
	logic           found_q;
	logic [RW-1:0]  pick_q;
	logic [ACC_W-1:0] best_q;
	logic [CCW-1:0] vc_q;
	logic [CW-1:0]  bcls_q;
	logic [5:0]     bvotes_q;

	logic [ACC_W-1:0] dist_rd;
	assign dist_rd = dvalid_q[r_s1] ? dist_s1 : '0;

	logic in_fire;
	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire = in_valid && in_ready;
	assign out_valid = (state_q == ST_OUT);

	logic load_ok;
	assign load_ok = (32'(in_data.class_id) < CLASS_COUNT)
		&& (32'(in_data.sample_index) < REFS_PER_CLASS)
		&& (32'(in_data.bin_index) < BIN_COUNT);

	logic [AW-1:0] load_addr;
	assign load_addr = AW'((32'(in_data.class_id) * REFS_PER_CLASS
		+ 32'(in_data.sample_index)) * BIN_COUNT + 32'(in_data.bin_index));

	logic issue;
	logic [RW-1:0] rd_idx;
	assign rd_idx = rd_cnt_q[RW-1:0];
	assign issue = (state_q == ST_ACC || state_q == ST_SEL) && (32'(rd_cnt_q) < REF_TOTAL);

	// reference store
	always_ff @(posedge clk) begin
		if (in_fire && in_data.req_type == REQ_LOAD && load_ok)
			ref_mem[load_addr] <= BIN_BITS'(in_data.bin_value);
		refv_s1 <= ref_mem[AW'(32'(rd_idx) * BIN_COUNT + 32'(bin_q))];
	end

	// distance memory: read port at sweep index, write from stage 2
	always_ff @(posedge clk) begin
		dist_s1 <= dist_mem[rd_idx];
		if (v_s2 && state_q == ST_ACC)
			dist_mem[r_s2] <= sat;
	end

	logic [BIN_BITS-1:0] diff;
	assign diff = (qval_q >= refv_s1) ? qval_q - refv_s1 : refv_s1 - qval_q;
	logic [ACC_W:0] sum;
	assign sum = {1'b0, acc_s2} + (ACC_W+1)'(sq_s2);
	logic [ACC_W-1:0] sat;
	assign sat = sum[ACC_W] ? '1 : sum[ACC_W-1:0];

	// class of the picked reference: compare against class boundaries
	logic [CW-1:0] pick_cls;
	always_comb begin
		pick_cls = '0;
		for (int c = 1; c < CLASS_COUNT; c++)
			if (32'(pick_q) >= c * REFS_PER_CLASS) pick_cls = CW'(c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= 6'd1;
			dvalid_q <= '0;
			sel_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			rd_cnt_q <= '0;
			last_q <= 1'b0;
			k_left_q <= '0;
			found_q <= 1'b0;
			pick_q <= '0;
			best_q <= '0;
			vc_q <= '0;
			bcls_q <= '0;
			bvotes_q <= '0;
			for (int c = 0; c < CLASS_COUNT; c++) votes_q[c] <= '0;
		end else begin
			if (cfg_valid) k_q <= cfg_data;
			v_s1 <= issue;
			v_s2 <= v_s1 && state_q == ST_ACC;
			if (issue) rd_cnt_q <= rd_cnt_q + 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && in_data.req_type == REQ_QUERY) begin
						rd_cnt_q <= '0;
						last_q <= in_data.last_bin;
						k_left_q <= (32'(k_q) > REF_TOTAL) ? 6'(REF_TOTAL) : k_q;
						if (32'(in_data.bin_index) < BIN_COUNT) state_q <= ST_ACC;
						else if (in_data.last_bin) begin
							state_q <= ST_SEL;
							found_q <= 1'b0;
						end
					end
				end
				ST_ACC: begin
					if (v_s2) dvalid_q[r_s2] <= 1'b1;
					if (v_s2 && 32'(r_s2) == REF_TOTAL - 1) begin
						rd_cnt_q <= '0;
						found_q <= 1'b0;
						state_q <= last_q ? ST_SEL : ST_IDLE;
					end
				end
				ST_SEL: begin
					if (k_left_q == '0) begin
						state_q <= ST_VOTE;
						vc_q <= '0;
						bvotes_q <= '0;
						bcls_q <= '0;
					end else if (v_s1) begin
						if (!sel_q[r_s1] && (!found_q || dist_rd < best_q)) begin
							found_q <= 1'b1;
							best_q <= dist_rd;
							pick_q <= r_s1;
						end
					end else if (!issue && 32'(rd_cnt_q) >= REF_TOTAL) begin
						sel_q[pick_q] <= 1'b1;
						votes_q[pick_cls] <= votes_q[pick_cls] + 6'd1;
						k_left_q <= k_left_q - 6'd1;
						rd_cnt_q <= '0;
						found_q <= 1'b0;
					end
				end
				ST_VOTE: begin
					if (32'(vc_q) < CLASS_COUNT) begin
						if (votes_q[vc_q[CW-1:0]] > bvotes_q) begin
							bvotes_q <= votes_q[vc_q[CW-1:0]];
							bcls_q <= vc_q[CW-1:0];
						end
						vc_q <= vc_q + 1'b1;
					end else state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
						dvalid_q <= '0;
						sel_q <= '0;
						for (int c = 0; c < CLASS_COUNT; c++) votes_q[c] <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) r_s1 <= rd_idx;
		r_s2 <= r_s1;
		sq_s2 <= SQW'(diff) * SQW'(diff);
		acc_s2 <= dist_rd;
		if (in_fire) begin
			bin_q <= BW'(in_data.bin_index);
			qval_q <= BIN_BITS'(in_data.bin_value);
		end
	end

	always_comb begin
		out_data.predicted_class = 2'(bcls_q);
		out_data.winning_votes = bvotes_q;
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("input taken while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed under stall");
	a_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> state_q == ST_ACC) else $error("stage 2 outside accumulate");
endmodule
